// File: sv/obd_pkg.sv
// ----------------------------------------------------------------------------
// OBD response line decoder package
// Shared codes, widths and the record passed from the parser to the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package obd_pkg;

    localparam int RAW_W    = 32;
    localparam int SCALED_W = 41;
    localparam int CODE_W   = 3;

    // Signal codes; the two highest codes are only used inside the parser.
    localparam logic [CODE_W-1:0] SIG_RPM          = 3'd0;
    localparam logic [CODE_W-1:0] SIG_SPEED        = 3'd1;
    localparam logic [CODE_W-1:0] SIG_COOLANT      = 3'd2;
    localparam logic [CODE_W-1:0] SIG_INTAKE       = 3'd3;
    localparam logic [CODE_W-1:0] SIG_THROTTLE     = 3'd4;
    localparam logic [CODE_W-1:0] SIG_MANIFOLD     = 3'd5;
    localparam logic [CODE_W-1:0] PID_ZERO_PENDING = 3'd6;
    localparam logic [CODE_W-1:0] PID_NONE         = 3'd7;

    // Number of base-256 folding steps in the divide-by-255 pipeline.
    localparam int NSTEP = 4;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [RAW_W-1:0]  raw;
    } line_t;

endpackage

`default_nettype wire

// File: sv/obd_byte_if.sv
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one ASCII character per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface obd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: sv/obd_result_if.sv
// ----------------------------------------------------------------------------
// Decoded result channel
// Valid/ready channel carrying one decoded quantity per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface obd_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         signal_code;
    logic signed [40:0] scaled_value;
    logic signed [31:0] raw_value;

    modport source (output valid, output signal_code, output scaled_value,
                    output raw_value, input ready);
    modport sink   (input valid, input signal_code, input scaled_value,
                    input raw_value, output ready);
endinterface

`default_nettype wire

// File: sv/obd_line_parser.sv
// ----------------------------------------------------------------------------
// OBD line parser
// Tokenises the character stream and registers one record per valid line.
// ----------------------------------------------------------------------------
`default_nettype none

module obd_line_parser
    import obd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    obd_byte_if.sink    rx,
    output line_t       line,
    output logic        line_valid,
    input  wire logic   line_ready
);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    logic [1:0]        token_index_reg, token_index_next;
    logic              in_token_reg, in_token_next;
    logic [3:0]        char_pos_reg, char_pos_next;
    logic              header_ok_reg, header_ok_next;
    logic [CODE_W-1:0] pid_reg, pid_next;
    logic [RAW_W-1:0]  acc_reg, acc_next;
    logic [RAW_W-1:0]  line_value_reg, line_value_next;
    logic              line_bad_reg, line_bad_next;
    logic              line_valid_reg, line_valid_next;
    line_t             line_reg, line_next;

    logic [7:0] c;
    logic       accept;
    logic       is_sep;
    logic       emit;
    logic [4:0] hex;

    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'b0_0000;
        if (ch >= "0" && ch <= "9") r = {1'b1, 4'(ch - "0")};
        else if (ch >= "A" && ch <= "F") r = {1'b1, 4'(ch - "A" + 8'd10)};
        else if (ch >= "a" && ch <= "f") r = {1'b1, 4'(ch - "a" + 8'd10)};
        return r;
    endfunction

    assign c        = rx.rx_byte;
    assign rx.ready = !line_valid_reg || line_ready;
    assign accept   = rx.valid && rx.ready;
    assign is_sep   = (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
                      (c == CH_FF) || (c == CH_SPACE);
    assign hex      = hex_digit(c);

    always_comb
    begin
        token_index_next = token_index_reg;
        in_token_next    = in_token_reg;
        char_pos_next    = char_pos_reg;
        header_ok_next   = header_ok_reg;
        pid_next         = pid_reg;
        acc_next         = acc_reg;
        line_value_next  = line_value_reg;
        line_bad_next    = line_bad_reg;
        emit             = 1'b0;
        line_next        = line_reg;

        if (accept)
        begin
            if ((c == CH_CR || is_sep) && in_token_reg)
            begin
                if (token_index_reg == 2'd1)
                begin
                    if (char_pos_reg != 4'd2) header_ok_next = 1'b0;
                end
                else if (token_index_reg == 2'd2)
                begin
                    if (char_pos_reg != 4'd2) pid_next = PID_NONE;
                end
                else
                begin
                    if (acc_reg[RAW_W-1]) line_bad_next = 1'b1;
                    line_value_next = {line_value_reg[RAW_W-9:0], acc_reg[7:0]};
                end
                in_token_next = 1'b0;
            end

            if (c == CH_CR)
            begin
                emit = (token_index_next == 2'd3) && header_ok_next && !line_bad_next &&
                       (pid_next <= SIG_MANIFOLD);
                line_next.code   = pid_next;
                line_next.raw    = line_value_next;
                token_index_next = 2'd0;
                in_token_next    = 1'b0;
                char_pos_next    = 4'd0;
                header_ok_next   = 1'b1;
                pid_next         = PID_NONE;
                acc_next         = '0;
                line_value_next  = '0;
                line_bad_next    = 1'b0;
            end
            else if (!is_sep)
            begin
                if (!in_token_reg)
                begin
                    in_token_next = 1'b1;
                    if (token_index_reg != 2'd3) token_index_next = token_index_reg + 2'd1;
                    char_pos_next = 4'd0;
                    acc_next      = '0;
                end

                if (token_index_next == 2'd1)
                begin
                    if (char_pos_next == 4'd0)
                    begin
                        if (c != "4") header_ok_next = 1'b0;
                    end
                    else if (char_pos_next == 4'd1)
                    begin
                        if (c != "1") header_ok_next = 1'b0;
                    end
                    else
                    begin
                        header_ok_next = 1'b0;
                    end
                end
                else if (token_index_next == 2'd2)
                begin
                    if (char_pos_next == 4'd0)
                    begin
                        if (c == "0") pid_next = PID_ZERO_PENDING;
                        else if (c == "1") pid_next = SIG_THROTTLE;
                        else pid_next = PID_NONE;
                    end
                    else if (char_pos_next == 4'd1)
                    begin
                        if (pid_reg == PID_ZERO_PENDING)
                        begin
                            case (c)
                                "C":     pid_next = SIG_RPM;
                                "D":     pid_next = SIG_SPEED;
                                "5":     pid_next = SIG_COOLANT;
                                "F":     pid_next = SIG_INTAKE;
                                "B":     pid_next = SIG_MANIFOLD;
                                default: pid_next = PID_NONE;
                            endcase
                        end
                        else if (pid_reg == SIG_THROTTLE)
                        begin
                            if (c != "1") pid_next = PID_NONE;
                        end
                        else
                        begin
                            pid_next = PID_NONE;
                        end
                    end
                    else
                    begin
                        pid_next = PID_NONE;
                    end
                end
                else
                begin
                    if (!hex[4] || char_pos_next >= 4'd8) line_bad_next = 1'b1;
                    else acc_next = {acc_next[RAW_W-5:0], hex[3:0]};
                end

                if (char_pos_next < 4'd9) char_pos_next = char_pos_next + 4'd1;
            end
        end
    end

    assign line_valid_next = (line_valid_reg && !line_ready) || emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_index_reg <= 2'd0;
            in_token_reg    <= 1'b0;
            char_pos_reg    <= 4'd0;
            header_ok_reg   <= 1'b1;
            pid_reg         <= PID_NONE;
            acc_reg         <= '0;
            line_value_reg  <= '0;
            line_bad_reg    <= 1'b0;
            line_valid_reg  <= 1'b0;
        end
        else
        begin
            token_index_reg <= token_index_next;
            in_token_reg    <= in_token_next;
            char_pos_reg    <= char_pos_next;
            header_ok_reg   <= header_ok_next;
            pid_reg         <= pid_next;
            acc_reg         <= acc_next;
            line_value_reg  <= line_value_next;
            line_bad_reg    <= line_bad_next;
            line_valid_reg  <= line_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) line_reg <= line_next;
    end

    assign line       = line_reg;
    assign line_valid = line_valid_reg;

endmodule

`default_nettype wire

// File: sv/obd_scaler.sv
// ----------------------------------------------------------------------------
// OBD value scaler
// Pipelined conversion of a line record to its Q.8 engineering value.
// ----------------------------------------------------------------------------
`default_nettype none

module obd_scaler
    import obd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire line_t  line,
    input  wire logic   line_valid,
    output logic        line_ready,
    obd_result_if.source res
);

    localparam int PROD_W = 38;
    localparam int QUOT_W = 30;

    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [RAW_W-1:0]    raw;
        logic                neg;
        logic [PROD_W-1:0]   prod;
        logic [PROD_W-1:0]   rem;
        logic [QUOT_W-1:0]   quot;
        logic [SCALED_W-1:0] direct;
    } work_t;

    work_t               st_reg [NSTEP+1];
    work_t               st_next [NSTEP+1];
    logic [NSTEP:0]      st_valid_reg;
    logic [NSTEP+1:0]    ld;
    logic                out_valid_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic [SCALED_W-1:0] out_scaled_reg, out_scaled_next;
    logic [RAW_W-1:0]    out_raw_reg;

    logic [RAW_W-1:0]    mag_in;
    logic [RAW_W:0]      less40;
    logic [QUOT_W-1:0]   quot_fin;
    logic [PROD_W-1:0]   mag_fin;

    function automatic work_t fold_step(input work_t w);
        work_t r;
        r      = w;
        r.rem  = PROD_W'(w.rem[PROD_W-1:8]) + PROD_W'(w.rem[7:0]);
        r.quot = w.quot + QUOT_W'(w.rem[PROD_W-1:8]);
        return r;
    endfunction

    always_comb
    begin
        ld[NSTEP+1] = !out_valid_reg || res.ready;
        for (int k = NSTEP; k >= 0; k--)
        begin
            ld[k] = !st_valid_reg[k] || ld[k+1];
        end
    end

    assign line_ready = ld[0];

    assign mag_in = line.raw[RAW_W-1] ? (~line.raw + 32'd1) : line.raw;
    assign less40 = {line.raw[RAW_W-1], line.raw} - 33'd40;

    always_comb
    begin
        st_next[0].code = line.code;
        st_next[0].raw  = line.raw;
        st_next[0].neg  = line.raw[RAW_W-1];
        st_next[0].prod = PROD_W'(mag_in) * PROD_W'(7'd100);
        st_next[0].rem  = PROD_W'(mag_in) * PROD_W'(7'd100);
        st_next[0].quot = '0;
        case (line.code)
            SIG_RPM:     st_next[0].direct = {{3{line.raw[RAW_W-1]}}, line.raw, 6'b0};
            SIG_COOLANT,
            SIG_INTAKE:  st_next[0].direct = {less40, 8'b0};
            default:     st_next[0].direct = {line.raw[RAW_W-1], line.raw, 8'b0};
        endcase
        for (int k = 1; k <= NSTEP; k++)
        begin
            st_next[k] = fold_step(st_reg[k-1]);
        end
    end

    assign quot_fin = st_reg[NSTEP].quot + QUOT_W'(st_reg[NSTEP].rem >= PROD_W'(255));
    assign mag_fin  = st_reg[NSTEP].prod + PROD_W'(quot_fin);

    always_comb
    begin
        if (st_reg[NSTEP].code == SIG_THROTTLE)
        begin
            if (st_reg[NSTEP].neg) out_scaled_next = -SCALED_W'(mag_fin);
            else out_scaled_next = SCALED_W'(mag_fin);
        end
        else
        begin
            out_scaled_next = st_reg[NSTEP].direct;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld[0]) st_valid_reg[0] <= line_valid;
            for (int k = 1; k <= NSTEP; k++)
            begin
                if (ld[k]) st_valid_reg[k] <= st_valid_reg[k-1];
            end
            if (ld[NSTEP+1]) out_valid_reg <= st_valid_reg[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= NSTEP; k++)
        begin
            if (ld[k]) st_reg[k] <= st_next[k];
        end
        if (ld[NSTEP+1])
        begin
            out_code_reg   <= st_reg[NSTEP].code;
            out_scaled_reg <= out_scaled_next;
            out_raw_reg    <= st_reg[NSTEP].raw;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.signal_code  = out_code_reg;
    assign res.scaled_value = out_scaled_reg;
    assign res.raw_value    = out_raw_reg;

endmodule

`default_nettype wire

// File: sv/obd_response_line_decoder.sv
// ----------------------------------------------------------------------------
// OBD response line decoder
// Decodes mode 01 response lines from a character stream into scaled values.
// ----------------------------------------------------------------------------
// The rx channel takes one ASCII character per beat; a carriage return closes
// the line. The res channel gives one beat per accepted line with a known
// PID: the signal code, the value in signed Q.8 and the assembled raw bytes.
// A character is taken in every cycle while the line register is free, so the
// sustained rate is one beat per cycle. The result reaches res after the
// carriage return beat passes the line register, the multiply stage, the
// four divide-by-255 folding stages and then the output register. Each stage
// holds its beat while the next one is full, so a stall on res fills the
// pipeline before rx ready falls, and nothing is dropped. Reset clears the
// tokeniser to the start of a line and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module obd_response_line_decoder
    import obd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    obd_byte_if.sink     rx,
    obd_result_if.source res
);

    line_t line;
    logic  line_valid;
    logic  line_ready;

    obd_line_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .line       (line),
        .line_valid (line_valid),
        .line_ready (line_ready)
    );

    obd_scaler u_scaler (
        .clk        (clk),
        .rst_n      (rst_n),
        .line       (line),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .res        (res)
    );

endmodule

`default_nettype wire
